### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define NCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ncc assertion failed");

// expression must never be true outside reset
`define NCC_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ncc forbidden condition");

`endif

### rtl/ncc_pkg.sv
// types, constants and helper functions of the n-gram context counter
package ncc_pkg;

    localparam int WINDOW_LEN  = 5;
    localparam int TABLE_SLOTS = 1024;
    localparam int TOKEN_KINDS = 256;

    localparam int OP_W    = 2;
    localparam int TOK_W   = 8;
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int LEN_W   = 3;
    localparam int CNT_W   = 16;
    localparam int USED_W  = $clog2(TABLE_SLOTS + 1);
    localparam int KIND_W  = $clog2(TOKEN_KINDS);
    localparam int WIDX_W  = $clog2(WINDOW_LEN);

    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2  = 32'h1b873593;
    localparam logic [31:0] MUR_ADD = 32'he6546b64;
    localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;
    localparam logic [31:0] PAD_WORD = 32'hFFFFFFFF;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TOK_W-1:0]  token;
        logic [SLOT_W-1:0] slot;
    } item_t;

    typedef struct packed {
        logic              status;
        logic              slot_valid;
        logic [LEN_W-1:0]  context_length;
        logic [TOK_W-1:0]  context_token0;
        logic [TOK_W-1:0]  context_token1;
        logic [TOK_W-1:0]  context_token2;
        logic [TOK_W-1:0]  context_token3;
        logic [TOK_W-1:0]  context_token4;
        logic [CNT_W-1:0]  follow_count;
        logic [USED_W-1:0] slots_used;
    } result_t;

    typedef enum logic [1:0] {
        CMD_COUNT,
        CMD_READ,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [TOK_W-1:0]  token;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

    typedef logic [WINDOW_LEN-1:0][TOK_W-1:0] window_t;

    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] length;
        window_t          tok;
    } slot_entry_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

### rtl/ncc_fifo.sv
// small synchronous queue used between the front, the engine and the result port
module ncc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W:0]   wptr_reg, wptr_next;
    logic [PTR_W:0]   rptr_reg, rptr_next;

    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[PTR_W] != rptr_reg[PTR_W])
                && (wptr_reg[PTR_W-1:0] == rptr_reg[PTR_W-1:0]);
    assign rdata = store_reg[rptr_reg[PTR_W-1:0]];

    always_comb
    begin
        wptr_next = wptr_reg + ((push && !full) ? 1'b1 : 1'b0);
        rptr_next = rptr_reg + ((pop && !empty) ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            store_reg[wptr_reg[PTR_W-1:0]] <= wdata;
        end
    end

    `NCC_NEVER(a_full_and_empty, clk, rst_n, full && empty)
    `NCC_NEVER(a_no_push_full, clk, rst_n, push && full)
    `NCC_ASSERT(a_fill_bound, clk, rst_n, (wptr_reg - rptr_reg) <= (PTR_W+1)'(DEPTH))

endmodule

### rtl/ncc_front.sv
// front part: accepts items, classifies them into commands and queues them
module ncc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ncc_pkg::item_t item,
    output logic           full,
    input  logic           cmd_pop,
    output ncc_pkg::cmd_t  cmd,
    output logic           cmd_valid
);
    import ncc_pkg::*;

    cmd_t                 cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;
    logic                 cmd_empty;
    logic                 tok_ok;

    assign tok_ok = ({1'b0, item.token} < (TOK_W+1)'(TOKEN_KINDS));

    always_comb
    begin
        cmd_in.token = item.token;
        cmd_in.slot  = item.slot;
        unique case (item.operation)
            OP_COUNT: cmd_in.kind = tok_ok ? CMD_COUNT : CMD_NOP;
            OP_READ:  cmd_in.kind = CMD_READ;
            OP_CLEAR: cmd_in.kind = CMD_CLEAR;
            default:  cmd_in.kind = CMD_NOP;
        endcase
    end

    ncc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !cmd_empty;

endmodule

### rtl/ncc_hash.sv
// multi-cycle murmur3-32 context hash, one multiply per cycle
module ncc_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  seed,
    input  logic [ncc_pkg::LEN_W-1:0]    len,
    input  ncc_pkg::window_t             words,
    output logic                         done,
    output logic [31:0]                  hash
);
    import ncc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [6:0] {
        H_IDLE = 7'b0000001,
        H_MUL1 = 7'b0000010,
        H_MUL2 = 7'b0000100,
        H_MIX  = 7'b0001000,
        H_FIN1 = 7'b0010000,
        H_FIN2 = 7'b0100000,
        H_FIN3 = 7'b1000000
    } hash_state_t;

    hash_state_t       state_reg, state_next;
    logic [31:0]       h_reg, h_next;
    logic [31:0]       k_reg, k_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [31:0]       word;
    logic [31:0]       r;
    logic [31:0]       t;

    always_comb
    begin
        word = (LEN_W'(idx_reg) < len_reg)
             ? {{(32-TOK_W){1'b0}}, words[idx_reg]} : PAD_WORD;
        r = '0;
        t = '0;
        state_next = state_reg;
        h_next = h_reg;
        k_next = k_reg;
        idx_next = idx_reg;
        len_next = len_reg;
        done = 1'b0;
        hash = h_reg ^ (h_reg >> 16);
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    h_next = seed;
                    idx_next = '0;
                    len_next = len;
                    state_next = H_MUL1;
                end
            end
            H_MUL1:
            begin
                k_next = word * MUR_C1;
                state_next = H_MUL2;
            end
            H_MUL2:
            begin
                k_next = rotl32(k_reg, 15) * MUR_C2;
                state_next = H_MIX;
            end
            H_MIX:
            begin
                r = rotl32(h_reg ^ k_reg, 13);
                h_next = (r << 2) + r + MUR_ADD;
                if (idx_reg == WIDX_W'(WINDOW_LEN - 1))
                begin
                    state_next = H_FIN1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = H_MUL1;
                end
            end
            H_FIN1:
            begin
                t = h_reg ^ {{(32-LEN_W){1'b0}}, len_reg};
                t = t ^ (t >> 16);
                h_next = t * MUR_F1;
                state_next = H_FIN2;
            end
            H_FIN2:
            begin
                t = h_reg ^ (h_reg >> 13);
                h_next = t * MUR_F2;
                state_next = H_FIN3;
            end
            H_FIN3:
            begin
                done = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        k_reg   <= k_next;
        idx_reg <= idx_next;
        len_reg <= len_next;
    end

    `NCC_ASSERT(a_start_idle, clk, rst_n, start |-> state_reg == H_IDLE)
    `NCC_ASSERT(a_done_then_idle, clk, rst_n, done |=> state_reg == H_IDLE)
    `NCC_ASSERT(a_mix_after_mul, clk, rst_n, state_reg == H_MIX |-> $past(state_reg) == H_MUL2)

endmodule

### rtl/ncc_engine.sv
// back part: window, slot table, probing, follow counts and result assembly
module ncc_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           seed,
    input  ncc_pkg::cmd_t         cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  logic                  res_full,
    output logic                  res_push,
    output ncc_pkg::result_t      res_data,
    output logic                  busy
);
    import ncc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [11:0] {
        E_IDLE   = 12'b000000000001,
        E_HSTART = 12'b000000000010,
        E_HWAIT  = 12'b000000000100,
        E_PRD    = 12'b000000001000,
        E_PCHK   = 12'b000000010000,
        E_ZERO   = 12'b000000100000,
        E_CRD    = 12'b000001000000,
        E_CWR    = 12'b000010000000,
        E_WIN    = 12'b000100000000,
        E_RCHK   = 12'b001000000000,
        E_RESP   = 12'b010000000000,
        E_SWEEP  = 12'b100000000000
    } eng_state_t;

    localparam int CADDR_W = SLOT_W + KIND_W;

    eng_state_t         state_reg, state_next;
    window_t            win_reg, win_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [SLOT_W-1:0]  probe_reg, probe_next;
    logic [SLOT_W-1:0]  start_reg, start_next;
    logic [SLOT_W-1:0]  sidx_reg, sidx_next;
    logic [KIND_W-1:0]  zidx_reg, zidx_next;
    logic [TOK_W-1:0]   tok_reg, tok_next;
    logic               clrp_reg, clrp_next;
    result_t            res_reg, res_next;

    slot_entry_t        slot_mem [TABLE_SLOTS];
    slot_entry_t        slot_rdata_reg;
    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr;
    slot_entry_t        slot_wdata;
    logic [SLOT_W-1:0]  slot_raddr;

    logic [CNT_W-1:0]   cnt_mem [TABLE_SLOTS*TOKEN_KINDS];
    logic [CNT_W-1:0]   cnt_rdata_reg;
    logic               cnt_we;
    logic [CADDR_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CADDR_W-1:0] cnt_raddr;

    logic               h_start;
    logic               h_done;
    logic [31:0]        h_value;
    window_t            ctx;
    logic               match;
    logic [SLOT_W-1:0]  probe_inc;

    ncc_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (h_start),
        .seed  (seed),
        .len   (len_reg),
        .words (win_reg),
        .done  (h_done),
        .hash  (h_value)
    );

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            ctx[i] = (LEN_W'(i) < len_reg) ? win_reg[i] : '0;
        end
    end

    assign match = slot_rdata_reg.used && (slot_rdata_reg.length == len_reg)
                && (slot_rdata_reg.tok == ctx);
    assign probe_inc = probe_reg + 1'b1;
    assign busy = (state_reg == E_SWEEP);

    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        used_next  = used_reg;
        probe_next = probe_reg;
        start_next = start_reg;
        sidx_next  = sidx_reg;
        zidx_next  = zidx_reg;
        tok_next   = tok_reg;
        clrp_next  = clrp_reg;
        res_next   = res_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        h_start    = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = probe_reg;
        slot_wdata = '0;
        slot_raddr = probe_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = {probe_reg, zidx_reg};
        cnt_wdata  = '0;
        cnt_raddr  = {probe_reg, tok_reg[KIND_W-1:0]};
        res_data   = res_reg;
        res_data.slots_used = used_reg;

        unique case (state_reg)
            E_IDLE:
            begin
                slot_raddr = cmd.slot;
                cnt_raddr  = {cmd.slot, cmd.token[KIND_W-1:0]};
                if (cmd_valid && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    tok_next = cmd.token;
                    res_next = '0;
                    unique case (cmd.kind)
                        CMD_COUNT:
                        begin
                            len_next = LEN_W'(1);
                            state_next = (fill_reg == '0) ? E_WIN : E_HSTART;
                        end
                        CMD_READ:
                        begin
                            state_next = E_RCHK;
                        end
                        CMD_CLEAR:
                        begin
                            win_next  = '0;
                            fill_next = '0;
                            used_next = '0;
                            clrp_next = 1'b1;
                            state_next = E_RESP;
                        end
                        default:
                        begin
                            state_next = E_RESP;
                        end
                    endcase
                end
            end
            E_HSTART:
            begin
                h_start = 1'b1;
                state_next = E_HWAIT;
            end
            E_HWAIT:
            begin
                if (h_done)
                begin
                    probe_next = h_value[SLOT_W-1:0];
                    start_next = h_value[SLOT_W-1:0];
                    state_next = E_PRD;
                end
            end
            E_PRD:
            begin
                state_next = E_PCHK;
            end
            E_PCHK:
            begin
                if (match)
                begin
                    state_next = E_CRD;
                end
                else if (slot_rdata_reg.used)
                begin
                    if (probe_inc == start_reg)
                    begin
                        res_next.status = 1'b1;
                        state_next = E_RESP;
                    end
                    else
                    begin
                        probe_next = probe_inc;
                        state_next = E_PRD;
                    end
                end
                else
                begin
                    slot_we = 1'b1;
                    slot_wdata.used = 1'b1;
                    slot_wdata.length = len_reg;
                    slot_wdata.tok = ctx;
                    used_next = used_reg + 1'b1;
                    zidx_next = '0;
                    state_next = E_ZERO;
                end
            end
            E_ZERO:
            begin
                cnt_we = 1'b1;
                zidx_next = zidx_reg + 1'b1;
                if (zidx_reg == '1)
                begin
                    state_next = E_CRD;
                end
            end
            E_CRD:
            begin
                state_next = E_CWR;
            end
            E_CWR:
            begin
                cnt_we = 1'b1;
                cnt_waddr = {probe_reg, tok_reg[KIND_W-1:0]};
                cnt_wdata = cnt_rdata_reg + 1'b1;
                if (len_reg == fill_reg)
                begin
                    state_next = E_WIN;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                    state_next = E_HSTART;
                end
            end
            E_WIN:
            begin
                for (int i = WINDOW_LEN - 1; i > 0; i--)
                begin
                    win_next[i] = win_reg[i-1];
                end
                win_next[0] = tok_reg;
                if (fill_reg < LEN_W'(WINDOW_LEN))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = E_RESP;
            end
            E_RCHK:
            begin
                if (slot_rdata_reg.used)
                begin
                    res_next.slot_valid = 1'b1;
                    res_next.context_length = slot_rdata_reg.length;
                    res_next.context_token0 = slot_rdata_reg.tok[0];
                    res_next.context_token1 = slot_rdata_reg.tok[1];
                    res_next.context_token2 = slot_rdata_reg.tok[2];
                    res_next.context_token3 = slot_rdata_reg.tok[3];
                    res_next.context_token4 = slot_rdata_reg.tok[4];
                    res_next.follow_count = cnt_rdata_reg;
                end
                state_next = E_RESP;
            end
            E_RESP:
            begin
                res_push = 1'b1;
                if (clrp_reg)
                begin
                    clrp_next = 1'b0;
                    sidx_next = '0;
                    state_next = E_SWEEP;
                end
                else
                begin
                    state_next = E_IDLE;
                end
            end
            E_SWEEP:
            begin
                slot_we = 1'b1;
                slot_waddr = sidx_reg;
                sidx_next = sidx_reg + 1'b1;
                if (sidx_reg == '1)
                begin
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_SWEEP;
            win_reg   <= '0;
            fill_reg  <= '0;
            used_reg  <= '0;
            sidx_reg  <= '0;
            clrp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            used_reg  <= used_next;
            sidx_reg  <= sidx_next;
            clrp_reg  <= clrp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        probe_reg <= probe_next;
        start_reg <= start_next;
        zidx_reg  <= zidx_next;
        tok_reg   <= tok_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    `NCC_ASSERT(a_used_bound, clk, rst_n, used_reg <= USED_W'(TABLE_SLOTS))
    `NCC_NEVER(a_push_full, clk, rst_n, res_push && res_full)
    `NCC_ASSERT(a_pop_valid, clk, rst_n, cmd_pop |-> cmd_valid && state_reg == E_IDLE)

endmodule

### rtl/ngram_context_count_table_core.sv
// top level of the n-gram context counter: seed register, front, engine and result queue
//
// Counts which token follows each context of the last one to five tokens, with contexts
// stored in a 1024-slot hash table found by linear probing and 16-bit wrapping follow counts
// per slot and token. One item is worked on at a time. For each context length a count item
// hashes the context (one 32x32 multiply per cycle in the hash unit), then reads and checks
// the probed slots one after another, zeroes the count row of a newly claimed slot (one
// entry per cycle), and then reads and updates the count. After reset and after a clear
// item the whole slot table is swept, during which full stays high.
// Two-entry queues on each side let items and results move while the engine works.
module ngram_context_count_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ncc_pkg::item_t     item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output ncc_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import ncc_pkg::*;

    logic [31:0]               seed_reg;
    logic                      front_full;
    logic                      eng_busy;
    cmd_t                      cmd;
    logic                      cmd_valid;
    logic                      cmd_pop;
    logic                      res_full;
    logic                      res_push;
    result_t                   res_data;
    logic [$bits(result_t)-1:0] res_bits;

    assign cfg_ready = 1'b1;
    assign full = front_full || eng_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    ncc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !full),
        .item      (item),
        .full      (front_full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_valid (cmd_valid)
    );

    ncc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data),
        .busy      (eng_busy)
    );

    ncc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = result_t'(res_bits);

endmodule
